@@ sv/aip_pkg.sv @@
`timescale 1ns / 1ps

package aip_pkg;

   // field widths
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned RADIX_W = 6;
   localparam int unsigned DIGIT_W = 6;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 16;
   // accumulator times a 6-bit base, plus a digit
   localparam int unsigned PROD_W  = VALUE_W + RADIX_W;
   localparam int unsigned RSP_W   = VALUE_W + COUNT_W;

   localparam logic [COUNT_W-1:0] MAX_COUNT = 16'hFFFF;
   localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   // characters of interest
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

   // bases
   localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_DIGIT
   } phase_type;

   typedef struct packed {
      logic               is_blank;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
      logic               is_alnum;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

   typedef struct packed {
      logic               emit;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] consumed;
   } parse_result_type;

endpackage

@@ sv/aip_char_decode.sv @@
`timescale 1ns / 1ps

module aip_char_decode (
   input  logic [aip_pkg::CHAR_W-1:0] char_code,
   output aip_pkg::char_class_type    cls
);

   // sort the character and find its digit value
   always_comb begin
      cls          = '0;
      cls.is_blank = (char_code == aip_pkg::CH_TAB) || (char_code == aip_pkg::CH_BLANK);
      cls.is_minus = (char_code == aip_pkg::CH_MINUS);
      cls.is_zero  = (char_code == aip_pkg::CH_ZERO);
      cls.is_x     = (char_code == aip_pkg::CH_LC_X);
      if (char_code >= aip_pkg::CH_ZERO && char_code <= aip_pkg::CH_NINE) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::DIGIT_W'(char_code - aip_pkg::CH_ZERO);
      end else if (char_code >= aip_pkg::CH_LC_A && char_code <= aip_pkg::CH_LC_Z) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::DIGIT_W'(char_code - aip_pkg::CH_LC_A + aip_pkg::LETTER_OFS);
      end else if (char_code >= aip_pkg::CH_UC_A && char_code <= aip_pkg::CH_UC_Z) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::DIGIT_W'(char_code - aip_pkg::CH_UC_A + aip_pkg::LETTER_OFS);
      end
   end

endmodule

@@ sv/aip_parse_core.sv @@
`timescale 1ns / 1ps

module aip_parse_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  aip_pkg::char_class_type         cls,
   input  logic [aip_pkg::RADIX_W-1:0]     radix,
   output aip_pkg::parse_result_type       result
);

   aip_pkg::phase_type              ph_ff,  ph_in;
   logic [aip_pkg::VALUE_W-1:0]     acc_ff, acc_in;
   logic                            neg_ff, neg_in;
   logic [aip_pkg::RADIX_W-1:0]     wb_ff,  wb_in;
   logic [aip_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                            sat_ff, sat_in;

   logic [aip_pkg::COUNT_W-1:0]     cnt_inc;
   logic [aip_pkg::RADIX_W-1:0]     dflt_base;
   logic [aip_pkg::RADIX_W-1:0]     base_sel;
   logic                            dig_ok;
   logic                            wrap_base;
   logic [aip_pkg::PROD_W-1:0]      prod;
   logic [aip_pkg::PROD_W-1:0]      sum;
   logic                            over;
   logic                            go_digit;
   logic                            emit_zero;
   logic                            emit_num;

   assign cnt_inc   = (cnt_ff == aip_pkg::MAX_COUNT) ? cnt_ff : cnt_ff + 1'b1;
   assign dflt_base = (radix == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : radix;

   // multiply-add; accumulator is zero until the base is fixed, so the
   // stored base is good enough for the multiplier
   assign prod = aip_pkg::PROD_W'(acc_ff) * aip_pkg::PROD_W'(wb_ff);
   assign sum  = prod + aip_pkg::PROD_W'(cls.digit);
   assign over = sat_ff || (sum[aip_pkg::PROD_W-1:aip_pkg::VALUE_W-1] != '0);

   assign dig_ok    = (base_sel >= aip_pkg::BASE_MIN) && (base_sel <= aip_pkg::BASE_MAX) &&
                      cls.is_alnum && (cls.digit < base_sel);
   assign wrap_base = (base_sel == aip_pkg::BASE_DEC) || (base_sel == aip_pkg::BASE_HEX);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= aip_pkg::PH_SPACE;
         acc_ff <= '0;
         neg_ff <= 1'b0;
         wb_ff  <= '0;
         cnt_ff <= '0;
         sat_ff <= 1'b0;
      end else if (step) begin
         ph_ff  <= ph_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         wb_ff  <= wb_in;
         cnt_ff <= cnt_in;
         sat_ff <= sat_in;
      end
   end

   // next state and result
   always_comb begin
      ph_in     = ph_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      wb_in     = wb_ff;
      cnt_in    = cnt_ff;
      sat_in    = sat_ff;
      go_digit  = 1'b0;
      emit_zero = 1'b0;
      emit_num  = 1'b0;
      base_sel  = wb_ff;

      unique case (ph_ff) inside
         aip_pkg::PH_SPACE, aip_pkg::PH_SIGN: begin
            if (ph_ff == aip_pkg::PH_SPACE && cls.is_blank) begin
               cnt_in = cnt_inc;
            end else if (ph_ff == aip_pkg::PH_SPACE && cls.is_minus) begin
               neg_in = 1'b1;
               cnt_in = cnt_inc;
               ph_in  = aip_pkg::PH_SIGN;
            end else if (cls.is_zero) begin
               cnt_in = cnt_inc;
               ph_in  = aip_pkg::PH_ZERO;
            end else begin
               go_digit = 1'b1;
               base_sel = dflt_base;
            end
         end
         aip_pkg::PH_ZERO: begin
            if (cls.is_x) begin
               cnt_in = cnt_inc;
               if (radix != aip_pkg::BASE_AUTO && radix != aip_pkg::BASE_HEX) begin
                  emit_zero = 1'b1;
               end else begin
                  wb_in = aip_pkg::BASE_HEX;
                  ph_in = aip_pkg::PH_DIGIT;
               end
            end else if (radix != aip_pkg::BASE_AUTO && radix != aip_pkg::BASE_OCT) begin
               emit_zero = 1'b1;
            end else begin
               go_digit = 1'b1;
               base_sel = aip_pkg::BASE_OCT;
            end
         end
         aip_pkg::PH_DIGIT: begin
            go_digit = 1'b1;
         end
         default: begin
            go_digit = 1'b1;
         end
      endcase

      // digit accumulate, or end of number
      if (go_digit) begin
         wb_in = base_sel;
         ph_in = aip_pkg::PH_DIGIT;
         if (dig_ok) begin
            cnt_in = cnt_inc;
            if (wrap_base) begin
               acc_in = sum[aip_pkg::VALUE_W-1:0];
            end else if (over) begin
               sat_in = 1'b1;
               acc_in = aip_pkg::POS_LIMIT;
            end else begin
               acc_in = sum[aip_pkg::VALUE_W-1:0];
            end
         end else begin
            emit_num = 1'b1;
         end
      end

      result.emit     = emit_zero || emit_num;
      result.consumed = cnt_in;
      if (emit_num) begin
         result.value = neg_ff ? (aip_pkg::VALUE_W'(0) - acc_ff) : acc_ff;
      end else begin
         result.value = '0;
      end

      // restart after a result
      if (result.emit) begin
         ph_in  = aip_pkg::PH_SPACE;
         acc_in = '0;
         neg_in = 1'b0;
         wb_in  = '0;
         cnt_in = '0;
         sat_in = 1'b0;
      end
   end

endmodule

@@ sv/ascii_integer_parser_unit.sv @@
`timescale 1ns / 1ps

// channel | direction | word
// req_    | in        | tdata[7:0] char_code
// rsp_    | out       | tdata[63:0] value, tdata[79:64] consumed
// csr_    | in        | data[5:0] radix
//
// One character per cycle while no held result stalls the input. A character is
// taken into the input register; when it steps on, the parse state and the
// multiply-add on the 64-bit accumulator update, and a result lands in the
// output register, from which it is offered on the rsp_ channel.
// Reset (synchronous) returns the parser to whitespace skip and radix to 0.
// A held result stalls only characters that would end a number.
module ascii_integer_parser_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // char_code
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [aip_pkg::RSP_W-1:0]       rsp_tdata,   // value, consumed
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [aip_pkg::RADIX_W-1:0]     csr_data     // radix
);

   logic                              in_valid_ff;
   logic [aip_pkg::CHAR_W-1:0]        in_char_ff;
   logic [aip_pkg::RADIX_W-1:0]       radix_ff;
   logic                              out_valid_ff;
   logic [aip_pkg::RSP_W-1:0]         out_data_ff;
   logic                              step;
   aip_pkg::char_class_type           cls;
   aip_pkg::parse_result_type         result;

   // radix register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= aip_pkg::BASE_AUTO;
      end else if (csr_valid) begin
         radix_ff <= csr_data;
      end
   end

   // a character moves on unless it ends a number and the output is held
   assign step       = in_valid_ff && (!result.emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   aip_char_decode u_decode (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   aip_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cls    (cls),
      .radix  (radix_ff),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && result.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (step && result.emit) begin
         out_data_ff <= {result.consumed, result.value};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ tb/ascii_integer_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module ascii_integer_parser_unit_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [aip_pkg::VALUE_W-1:0] value;
      logic [aip_pkg::COUNT_W-1:0] consumed;
   } number_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [7:0]                   req_tdata;   // char_code
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [aip_pkg::RSP_W-1:0]    rsp_tdata;   // value, consumed
   logic                         csr_valid;
   logic                         csr_ready;
   logic [aip_pkg::RADIX_W-1:0]  csr_data;    // radix

   // parser shadow state
   logic [aip_pkg::RADIX_W-1:0]  radix_q;
   aip_pkg::phase_type           ph;
   logic [aip_pkg::VALUE_W-1:0]  acc;
   logic                         neg;
   logic [aip_pkg::RADIX_W-1:0]  wbase;
   logic [aip_pkg::COUNT_W-1:0]  cnt;
   logic                         sat;

   number_result_type   expected_numbers[$];
   int                  mismatches = 0;
   int                  sent_chars = 0;
   int                  cycle_count = 0;
   int                  rsp_hold_cycles = 0;
   bit                  no_idle = 1'b0;

   ascii_integer_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // parser prediction
   // ---------------------------------------------------------------
   function automatic void clear_number();
      ph    = aip_pkg::PH_SPACE;
      acc   = '0;
      neg   = 1'b0;
      wbase = '0;
      cnt   = '0;
      sat   = 1'b0;
   endfunction

   function automatic void bump_count();
      if (cnt < aip_pkg::MAX_COUNT) cnt++;
   endfunction

   // digit value 0..35, or all ones for a non-alphanumeric character
   function automatic logic [7:0] digit_value(logic [7:0] c);
      if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE) return c - aip_pkg::CH_ZERO;
      if (c >= aip_pkg::CH_LC_A && c <= aip_pkg::CH_LC_Z)
         return c - aip_pkg::CH_LC_A + aip_pkg::LETTER_OFS;
      if (c >= aip_pkg::CH_UC_A && c <= aip_pkg::CH_UC_Z)
         return c - aip_pkg::CH_UC_A + aip_pkg::LETTER_OFS;
      return 8'hFF;
   endfunction

   function automatic bit take_digit(logic [7:0] c);
      logic [7:0]                  d;
      logic [aip_pkg::VALUE_W-1:0] b64;
      logic [aip_pkg::VALUE_W-1:0] d64;
      d = digit_value(c);
      if (wbase < aip_pkg::BASE_MIN || wbase > aip_pkg::BASE_MAX || d >= {2'b00, wbase})
         return 1'b0;
      b64 = aip_pkg::VALUE_W'(wbase);
      d64 = aip_pkg::VALUE_W'(d);
      // ten and sixteen wrap, other bases saturate
      if (wbase == aip_pkg::BASE_DEC || wbase == aip_pkg::BASE_HEX) begin
         acc = acc * b64 + d64;
      end else if (sat || acc > (aip_pkg::POS_LIMIT - d64) / b64) begin
         sat = 1'b1;
         acc = aip_pkg::POS_LIMIT;
      end else begin
         acc = acc * b64 + d64;
      end
      bump_count();
      return 1'b1;
   endfunction

   function automatic void push_number(logic [aip_pkg::VALUE_W-1:0] v);
      number_result_type r;
      r.value    = v;
      r.consumed = cnt;
      expected_numbers.push_back(r);
      clear_number();
   endfunction

   function automatic void finish_number();
      push_number(neg ? -acc : acc);
   endfunction

   function automatic void begin_digits(logic [7:0] c, logic [aip_pkg::RADIX_W-1:0] base);
      wbase = base;
      ph    = aip_pkg::PH_DIGIT;
      if (!take_digit(c)) finish_number();
   endfunction

   function automatic void parse_char(logic [7:0] c);
      logic [aip_pkg::RADIX_W-1:0] dflt;
      dflt = (radix_q != aip_pkg::BASE_AUTO) ? radix_q : aip_pkg::BASE_DEC;
      if (ph == aip_pkg::PH_SPACE && (c == aip_pkg::CH_TAB || c == aip_pkg::CH_BLANK)) begin
         bump_count();
      end else if (ph == aip_pkg::PH_SPACE && c == aip_pkg::CH_MINUS) begin
         neg = 1'b1;
         bump_count();
         ph = aip_pkg::PH_SIGN;
      end else if (ph == aip_pkg::PH_SPACE || ph == aip_pkg::PH_SIGN) begin
         if (c == aip_pkg::CH_ZERO) begin
            bump_count();
            ph = aip_pkg::PH_ZERO;
         end else begin
            begin_digits(c, dflt);
         end
      end else if (ph == aip_pkg::PH_ZERO) begin
         // prefix decides the base; a clash with radix ends with zero
         if (c == aip_pkg::CH_LC_X) begin
            bump_count();
            if (radix_q != aip_pkg::BASE_AUTO && radix_q != aip_pkg::BASE_HEX) begin
               push_number('0);
            end else begin
               wbase = aip_pkg::BASE_HEX;
               ph    = aip_pkg::PH_DIGIT;
            end
         end else if (radix_q != aip_pkg::BASE_AUTO && radix_q != aip_pkg::BASE_OCT) begin
            push_number('0);
         end else begin
            begin_digits(c, aip_pkg::BASE_OCT);
         end
      end else begin
         if (!take_digit(c)) finish_number();
      end
   endfunction

   // ---------------------------------------------------------------
   // result check
   // ---------------------------------------------------------------
   function automatic void note_mismatch(string what, logic [aip_pkg::VALUE_W-1:0] exp_v,
                                         logic [aip_pkg::VALUE_W-1:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("MISMATCH %s: expected %0h actual %0h", what, exp_v, act_v);
   endfunction

   always @(posedge clock) begin
      number_result_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_numbers.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_tdata[aip_pkg::VALUE_W-1:0]);
         end else begin
            r = expected_numbers.pop_front();
            if (rsp_tdata[aip_pkg::VALUE_W-1:0] !== r.value)
               note_mismatch("value", r.value, rsp_tdata[aip_pkg::VALUE_W-1:0]);
            if (rsp_tdata[aip_pkg::RSP_W-1:aip_pkg::VALUE_W] !== r.consumed)
               note_mismatch("consumed", aip_pkg::VALUE_W'(r.consumed),
                             aip_pkg::VALUE_W'(rsp_tdata[aip_pkg::RSP_W-1:aip_pkg::VALUE_W]));
         end
      end
   end

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            @(negedge clock) rsp_tready = 1'b0;
            repeat (rsp_hold_cycles - 1) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = draw_gap();
         if (stall > 0) begin
            @(negedge clock) rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = c;
      do @(posedge clock); while (!req_tready);
      parse_char(c);
      sent_chars++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   task automatic quiet_and_drain();
      @(negedge clock) req_tvalid = 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      // a string in progress may still sit in the pipeline
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [aip_pkg::RADIX_W-1:0] v);
      quiet_and_drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      radix_q = v;
      @(negedge clock) csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic logic [7:0] digit_char(logic [aip_pkg::RADIX_W-1:0] base);
      int dv;
      if (base < aip_pkg::BASE_MIN || base > aip_pkg::BASE_MAX) dv = $urandom_range(0, 35);
      else dv = $urandom_range(0, base - 1);
      if (dv < 10) return aip_pkg::CH_ZERO + 8'(dv);
      return ($urandom_range(0, 1) ? aip_pkg::CH_LC_A : aip_pkg::CH_UC_A) + 8'(dv - 10);
   endfunction

   // one mostly well-formed number with random content, or a burst of noise
   task automatic send_random_number();
      int                          ws;
      int                          pre;
      int                          nd;
      logic [aip_pkg::RADIX_W-1:0] base;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
         return;
      end
      ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (ws) send_char($urandom_range(0, 1) ? aip_pkg::CH_TAB : aip_pkg::CH_BLANK);
      if ($urandom_range(0, 2) == 0) send_char(aip_pkg::CH_MINUS);
      base = (radix_q != aip_pkg::BASE_AUTO) ? radix_q : aip_pkg::BASE_DEC;
      if (radix_q == aip_pkg::BASE_AUTO) pre = $urandom_range(0, 2);
      else if (radix_q == aip_pkg::BASE_HEX) pre = $urandom_range(0, 1) ? 2 : 0;
      else if (radix_q == aip_pkg::BASE_OCT) pre = $urandom_range(0, 1);
      else pre = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      if (pre >= 1) begin
         send_char(aip_pkg::CH_ZERO);
         base = aip_pkg::BASE_OCT;
      end
      if (pre == 2) begin
         send_char(aip_pkg::CH_LC_X);
         base = aip_pkg::BASE_HEX;
      end
      nd = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
      repeat (nd) send_char(digit_char(base));
      case ($urandom_range(0, 3))
         0: send_char(8'h3B);
         1: send_char(8'h0A);
         2: send_char(aip_pkg::CH_BLANK);
         default: send_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic test_blank_and_sign();
      write_radix(aip_pkg::BASE_AUTO);
      send_text(" \t-42;");
      send_text("-;");
   endtask

   task automatic test_prefixes();
      send_text("0x1F;");
      send_text("017;");
      send_text("0;");
   endtask

   task automatic test_byte_extremes();
      send_char(8'h00);
      send_char(8'hFF);
   endtask

   // '0x' and '0' against a fixed decimal radix
   task automatic test_base_mismatch();
      write_radix(aip_pkg::BASE_DEC);
      send_text("0x5;");
      send_text("07;");
   endtask

   task automatic test_generic_saturation();
      write_radix(aip_pkg::BASE_MAX);
      send_text("-zzzzzzzzzzzzzZ;");
   endtask

   task automatic test_invalid_bases();
      write_radix(6'd1);
      send_text("5;");
      write_radix(6'd63);
      send_text("a;");
   endtask

   // results held back long enough to stall the character input
   task automatic test_result_backpressure();
      write_radix(aip_pkg::BASE_AUTO);
      rsp_hold_cycles = 400;
      no_idle = 1'b1;
      repeat (30) begin
         send_char(digit_char(aip_pkg::BASE_DEC));
         send_char(8'h3B);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_numbers(input logic [aip_pkg::RADIX_W-1:0] r, input int n_chars);
      int start;
      write_radix(r);
      no_idle = ($urandom_range(0, 3) == 0);
      start = sent_chars;
      while (sent_chars - start < n_chars) send_random_number();
      no_idle = 1'b0;
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      radix_q    = aip_pkg::BASE_AUTO;
      clear_number();
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_blank_and_sign();
      test_prefixes();
      test_byte_extremes();
      test_base_mismatch();
      test_generic_saturation();
      test_invalid_bases();
      test_random_numbers(aip_pkg::BASE_AUTO, 105);
      test_random_numbers(aip_pkg::BASE_DEC, 105);
      test_result_backpressure();
      test_random_numbers(aip_pkg::BASE_HEX, 105);
      test_random_numbers(aip_pkg::BASE_OCT, 105);
      test_random_numbers(aip_pkg::BASE_MIN, 105);
      test_random_numbers(aip_pkg::BASE_MAX, 105);
      test_random_numbers(aip_pkg::BASE_AUTO, 105);
      test_random_numbers(6'd1, 105);
      test_random_numbers(6'd63, 105);
      test_random_numbers(6'($urandom_range(0, 63)), 105);

      quiet_and_drain();
      if (mismatches == 0 && expected_numbers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
